// ===== src/debounce_and_pulse_timers_assert.svh =====
// Assertion macros shared by the timer block.
`ifndef DEBOUNCE_AND_PULSE_TIMERS_ASSERT_SVH
`define DEBOUNCE_AND_PULSE_TIMERS_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dpt_pkg.sv =====
package dpt_pkg;

  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_START_LED = 2'd1;
  localparam logic [1:0] ACT_FIRE      = 2'd2;
  localparam logic [1:0] ACT_SET_OFF   = 2'd3;

  localparam logic [1:0] REG_PRESS   = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_FLASH   = 2'd2;

  localparam logic [7:0] PRESS_RESET   = 8'd10;
  localparam logic [7:0] RELEASE_RESET = 8'd20;
  localparam logic [7:0] FLASH_RESET   = 8'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic        button_level;
    logic [15:0] led_duration_ms;
    logic [31:0] off_interval_ms;
  } in_t;

  typedef struct packed {
    logic        led_on;
    logic        flash_on;
    logic        button_pressed;
    logic [31:0] press_duration_ms;
    logic [31:0] off_remaining_ms;
  } out_t;

endpackage

// ===== src/debounce_and_pulse_timers.sv =====
// A result beat is registered into the output register, or into the skid entry while that is held.
// Throughput: one input beat per cycle; timer and debounce updates are a single
// pass of short logic (decrements/increments up to 32 bits) into the state regs. Under output
// stall the skid entry takes one more beat, then input stalls until it drains.
// Reset (rst, sync, active high) clears all timers, the LED and flash outputs,
// the debounced level and press count; registers reload 10 / 20 / 6.
module debounce_and_pulse_timers (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dpt_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output dpt_pkg::out_t    out_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  // configuration registers
  logic [7:0] press_ticks;
  logic [7:0] release_ticks;
  logic [7:0] flash_ticks;

  // timer / debounce state
  logic [15:0] led_remaining,   led_remaining_next;
  logic        led_level,       led_level_next;
  logic [7:0]  flash_remaining, flash_remaining_next;
  logic [31:0] off_remaining,   off_remaining_next;
  logic        debounced,       debounced_next;
  logic [7:0]  stable_cnt,      stable_cnt_next;
  logic [31:0] press_dur,       press_dur_next;

  // output side: result register plus one skid entry
  logic          skid_valid;
  dpt_pkg::out_t skid_data;
  dpt_pkg::out_t result;

  logic accept;
  logic out_take;
  logic out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = out_take || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= dpt_pkg::PRESS_RESET;
      release_ticks <= dpt_pkg::RELEASE_RESET;
      flash_ticks   <= dpt_pkg::FLASH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dpt_pkg::REG_PRESS:   press_ticks   <= cfg_data;
        dpt_pkg::REG_RELEASE: release_ticks <= cfg_data;
        dpt_pkg::REG_FLASH:   flash_ticks   <= cfg_data;
        default: ;  // index past the list: dropped
      endcase
    end
  end

  // Next state for one beat. Tick order: LED, flash, off countdown, debounce.
  always_comb begin
    logic [7:0] reload_same;
    logic [7:0] reload_flip;
    led_remaining_next   = led_remaining;
    led_level_next       = led_level;
    flash_remaining_next = flash_remaining;
    off_remaining_next   = off_remaining;
    debounced_next       = debounced;
    stable_cnt_next      = stable_cnt;
    press_dur_next       = press_dur;
    // countdown reload for the current level and for the opposite one
    reload_same = debounced ? release_ticks : press_ticks;
    reload_flip = debounced ? press_ticks : release_ticks;
    case (in_data.action)
      dpt_pkg::ACT_TICK: begin
        if (led_remaining != 16'd0) begin
          led_remaining_next = led_remaining - 16'd1;
          if (led_remaining == 16'd1) begin
            led_level_next = 1'b0;
          end
        end
        if (flash_remaining != 8'd0) begin
          flash_remaining_next = flash_remaining - 8'd1;
        end
        if (off_remaining != 32'd0) begin
          off_remaining_next = off_remaining - 32'd1;
        end
        if (in_data.button_level == debounced) begin
          // stable: reload and count pressed time, saturating
          stable_cnt_next = reload_same;
          if (debounced && press_dur != 32'hFFFF_FFFF) begin
            press_dur_next = press_dur + 32'd1;
          end
        end else begin
          press_dur_next = 32'd0;
          // countdown of 0 or 1 flips right away, no wrap
          if (stable_cnt <= 8'd1) begin
            debounced_next  = in_data.button_level;
            stable_cnt_next = reload_flip;
          end else begin
            stable_cnt_next = stable_cnt - 8'd1;
          end
        end
      end
      dpt_pkg::ACT_START_LED: begin
        // duration 0 leaves the counter idle, so the LED stays on
        led_remaining_next = in_data.led_duration_ms;
        led_level_next     = 1'b1;
      end
      dpt_pkg::ACT_FIRE: begin
        // a pulse length of 0 still gives a one-tick pulse
        flash_remaining_next = (flash_ticks != 8'd0) ? flash_ticks : 8'd1;
      end
      default: begin
        off_remaining_next = in_data.off_interval_ms;
      end
    endcase
  end

  always_comb begin
    result.led_on            = led_level_next;
    result.flash_on          = (flash_remaining_next != 8'd0);
    result.button_pressed    = debounced_next;
    result.press_duration_ms = debounced_next ? press_dur_next : 32'd0;
    result.off_remaining_ms  = off_remaining_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_remaining   <= 16'd0;
      led_level       <= 1'b0;
      flash_remaining <= 8'd0;
      off_remaining   <= 32'd0;
      debounced       <= 1'b0;
      stable_cnt      <= dpt_pkg::PRESS_RESET;
      press_dur       <= 32'd0;
    end else if (accept) begin
      led_remaining   <= led_remaining_next;
      led_level       <= led_level_next;
      flash_remaining <= flash_remaining_next;
      off_remaining   <= off_remaining_next;
      debounced       <= debounced_next;
      stable_cnt      <= stable_cnt_next;
      press_dur       <= press_dur_next;
    end
  end

  // Output control. Skid fills only when the result register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

`include "debounce_and_pulse_timers_assert.svh"

  `DPT_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid holds a beat with no result")
  `DPT_ASSERT_NEXT(a_skid_fill, accept && out_valid && out_stall, skid_valid, "stalled beat lost")
  `DPT_ASSERT_NOW(a_led_level, led_remaining != 16'd0, led_level, "LED off while timer runs")
  `DPT_ASSERT_NOW(a_press_clear, !debounced, press_dur == 32'd0, "press count while released")
  `DPT_ASSERT_NEXT(a_cnt_hold, !accept, $stable(stable_cnt), "debounce count moved without beat")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

  // Index 3 is not a register. A write to it must leave all three registers unchanged.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  dpt_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall = 1'b0;
  dpt_pkg::out_t  out_data;
  logic           cfg_write;
  logic [1:0]     cfg_index;
  logic [7:0]     cfg_data;

  always #4 clk = ~clk;

  debounce_and_pulse_timers i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Idle knobs, in percent per cycle. Each phase sets them.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Receiver stall: a fresh random draw every cycle. The DUT must hold its result beat.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Timer/debounce predictor: a private copy of the registers and the state
  // ---------------------------------------------------------------------------
  logic [7:0]  press_ticks_cfg;
  logic [7:0]  rel_ticks_cfg;
  logic [7:0]  pulse_ticks_cfg;

  logic [15:0] led_left;
  bit          led_lvl;
  logic [7:0]  flash_left;
  logic [31:0] off_left;
  bit          deb_lvl;
  logic [7:0]  stable_left;
  logic [31:0] press_count;

  dpt_pkg::out_t predicted_outputs[$];
  dpt_pkg::out_t want_beat;
  int            mismatch_count = 0;

  // Applies one action to the model state and returns the output levels after it.
  function automatic dpt_pkg::out_t advance_timers(input dpt_pkg::in_t beat);
    dpt_pkg::out_t r;
    case (beat.action)
      dpt_pkg::ACT_TICK: begin
        // Timer order: LED, flash, off countdown, then the debounce step.
        if (led_left != 0) begin
          led_left = led_left - 1'b1;
          if (led_left == 0)
            led_lvl = 1'b0;
        end
        if (flash_left != 0)
          flash_left = flash_left - 1'b1;
        if (off_left != 0)
          off_left = off_left - 1'b1;
        if (beat.button_level == deb_lvl) begin
          // Level is stable. Reload the countdown from the current registers.
          if (deb_lvl && press_count != 32'hFFFF_FFFF)
            press_count = press_count + 1'b1;
          stable_left = deb_lvl ? rel_ticks_cfg : press_ticks_cfg;
        end else begin
          press_count = '0;
          // A countdown at 0 or 1 accepts on this tick. Zero must not wrap.
          if (stable_left <= 8'd1) begin
            deb_lvl = beat.button_level;
            stable_left = deb_lvl ? rel_ticks_cfg : press_ticks_cfg;
          end else begin
            stable_left = stable_left - 1'b1;
          end
        end
      end
      dpt_pkg::ACT_START_LED: begin
        led_left = beat.led_duration_ms;
        led_lvl = 1'b1;
      end
      dpt_pkg::ACT_FIRE: begin
        // A pulse length of 0 still gives a one-tick pulse.
        flash_left = (pulse_ticks_cfg != 0) ? pulse_ticks_cfg : 8'd1;
      end
      default: begin
        off_left = beat.off_interval_ms;
      end
    endcase
    r.led_on            = led_lvl;
    r.flash_on          = (flash_left != 0);
    r.button_pressed    = deb_lvl;
    r.press_duration_ms = deb_lvl ? press_count : 32'd0;
    r.off_remaining_ms  = off_left;
    return r;
  endfunction

  // Monitor: at each edge it records config writes and accepted input beats,
  // and checks accepted result beats. A new prediction is pushed before the
  // check, so the queue order holds whatever the latency is.
  always @(posedge clk) begin
    if (rst) begin
      press_ticks_cfg = dpt_pkg::PRESS_RESET;
      rel_ticks_cfg   = dpt_pkg::RELEASE_RESET;
      pulse_ticks_cfg = dpt_pkg::FLASH_RESET;
      led_left        = '0;
      led_lvl         = 1'b0;
      flash_left      = '0;
      off_left        = '0;
      deb_lvl         = 1'b0;
      stable_left     = dpt_pkg::PRESS_RESET;
      press_count     = '0;
      predicted_outputs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          dpt_pkg::REG_PRESS:   press_ticks_cfg = cfg_data;
          dpt_pkg::REG_RELEASE: rel_ticks_cfg   = cfg_data;
          dpt_pkg::REG_FLASH:   pulse_ticks_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predicted_outputs.push_back(advance_timers(in_data));
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatch_count++;
        end else begin
          want_beat = predicted_outputs.pop_front();
          if (out_data.led_on !== want_beat.led_on) begin
            $error("led_on: expected %0d, got %0d", want_beat.led_on, out_data.led_on);
            mismatch_count++;
          end
          if (out_data.flash_on !== want_beat.flash_on) begin
            $error("flash_on: expected %0d, got %0d", want_beat.flash_on, out_data.flash_on);
            mismatch_count++;
          end
          if (out_data.button_pressed !== want_beat.button_pressed) begin
            $error("button_pressed: expected %0d, got %0d",
                   want_beat.button_pressed, out_data.button_pressed);
            mismatch_count++;
          end
          if (out_data.press_duration_ms !== want_beat.press_duration_ms) begin
            $error("press_duration_ms: expected %0d, got %0d",
                   want_beat.press_duration_ms, out_data.press_duration_ms);
            mismatch_count++;
          end
          if (out_data.off_remaining_ms !== want_beat.off_remaining_ms) begin
            $error("off_remaining_ms: expected %0d, got %0d",
                   want_beat.off_remaining_ms, out_data.off_remaining_ms);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Drives one input beat and returns at the edge that accepts it. Valid stays
  // high after that edge. The next caller lowers it or reuses it, so valid never
  // takes two assignments in one time step.
  task automatic send_beat(input dpt_pkg::in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops input and waits until every predicted result beat has been checked.
  // The first edge makes sure the beat accepted last has been pushed.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
  endtask

  // Writes the three registers back to back. The block must be idle.
  task automatic program_regs(input logic [7:0] press_v, input logic [7:0] rel_v,
                              input logic [7:0] pulse_v, input bit poke_unused);
    cfg_write <= 1'b1;
    cfg_index <= dpt_pkg::REG_PRESS;
    cfg_data  <= press_v;
    @(posedge clk);
    cfg_index <= dpt_pkg::REG_RELEASE;
    cfg_data  <= rel_v;
    @(posedge clk);
    cfg_index <= dpt_pkg::REG_FLASH;
    cfg_data  <= pulse_v;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= 8'hA5;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic dpt_pkg::in_t mk_beat(input logic [1:0] act, input logic lvl,
                                           input logic [15:0] dur, input logic [31:0] ivl);
    dpt_pkg::in_t b;
    b.action          = act;
    b.button_level    = lvl;
    b.led_duration_ms = dur;
    b.off_interval_ms = ivl;
    return b;
  endfunction

  // The raw button moves in runs of random length, with occasional one-tick
  // glitches. Runs longer than the stable times let the debouncer switch.
  bit raw_level = 1'b0;
  int run_left  = 0;
  int run_max   = 8;

  function automatic dpt_pkg::in_t random_beat();
    dpt_pkg::in_t b;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 70)      b.action = dpt_pkg::ACT_TICK;
    else if (pick < 80) b.action = dpt_pkg::ACT_START_LED;
    else if (pick < 90) b.action = dpt_pkg::ACT_FIRE;
    else                b.action = dpt_pkg::ACT_SET_OFF;
    if (b.action == dpt_pkg::ACT_TICK) begin
      if (run_left == 0) begin
        raw_level = ~raw_level;
        run_left = $urandom_range(run_max, 1);
      end
      run_left--;
      b.button_level = ($urandom_range(9) == 0) ? ~raw_level : raw_level;
    end else begin
      b.button_level = 1'($urandom_range(1));
    end
    case ($urandom_range(9))
      0:       b.led_duration_ms = 16'd0;
      1:       b.led_duration_ms = 16'hFFFF;
      2:       b.led_duration_ms = 16'($urandom);
      default: b.led_duration_ms = 16'($urandom_range(24, 1));
    endcase
    case ($urandom_range(9))
      0:       b.off_interval_ms = 32'd0;
      1:       b.off_interval_ms = 32'hFFFF_FFFF;
      2:       b.off_interval_ms = $urandom;
      default: b.off_interval_ms = $urandom_range(40, 1);
    endcase
    return b;
  endfunction

  // Random traffic under a single register setting and idle mix. With
  // pause_midway set, the sender stops halfway until every result is back.
  task automatic run_phase(input int beats, input int unsigned send_pct,
                           input int unsigned stall_pct, input logic [7:0] press_v,
                           input logic [7:0] rel_v, input logic [7:0] pulse_v,
                           input bit pause_midway);
    wait_results_drained();
    program_regs(press_v, rel_v, pulse_v, 1'b0);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    run_max = ((press_v > rel_v) ? press_v : rel_v) + 3;
    if (run_max > 40)
      run_max = 40;
    for (int i = 0; i < beats; i++) begin
      if (pause_midway && i == beats / 2)
        wait_results_drained();
      send_beat(random_beat());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Timer loads under the reset register values (10 / 20 / 6).
  task automatic test_timer_loads();
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0,    32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_START_LED, 1'b0, 16'd0,    32'hFFFF_FFFF)); // LED stays on
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(mk_beat(dpt_pkg::ACT_START_LED, 1'b1, 16'd1,    32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'd0,    32'd0));         // LED drops
    send_beat(mk_beat(dpt_pkg::ACT_START_LED, 1'b1, 16'hFFFF, 32'h5A5A_A5A5));
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'h1234, 32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_FIRE,      1'b1, 16'hFFFF, 32'hFFFF_FFFF)); // pulse of 6
    send_beat(mk_beat(dpt_pkg::ACT_SET_OFF,   1'b0, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0,    32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_SET_OFF,   1'b1, 16'd0,    32'd1));
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0,    32'd0));         // off expires
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0,    32'd0));         // no wrap
    send_beat(mk_beat(dpt_pkg::ACT_SET_OFF,   1'b0, 16'd0,    32'd0));
  endtask

  // A zero press time, a zero pulse length, and a register change that only
  // takes effect when the countdown reloads.
  task automatic test_debounce_edges();
    wait_results_drained();
    program_regs(8'd0, 8'd2, 8'd0, 1'b1);
    send_beat(mk_beat(dpt_pkg::ACT_FIRE,      1'b0, 16'd0, 32'd0));  // one-tick pulse
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'd0, 32'd0));  // old countdown of 10 runs
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0, 32'd0));  // reload, now 0
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'd0, 32'd0));  // press accepted at once
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'd0, 32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b1, 16'd0, 32'd0));
    send_beat(mk_beat(dpt_pkg::ACT_START_LED, 1'b0, 16'd3, 32'd0));  // non-tick ignores level
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0, 32'd0));  // glitch: count clears
    send_beat(mk_beat(dpt_pkg::ACT_TICK,      1'b0, 16'd0, 32'd0));  // release accepted
  endtask

  task automatic test_streaming();
    run_phase(120, 0, 0, 8'd3, 8'd5, 8'd2, 1'b0);
  endtask

  task automatic test_sender_gaps();
    run_phase(100, 63, 0, 8'd1, 8'd1, 8'd1, 1'b0);
  endtask

  task automatic test_receiver_stalls();
    run_phase(100, 0, 63, 8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)),
              8'($urandom_range(12, 1)), 1'b0);
  endtask

  // Both sides idle. The sender pauses midway until every result is back.
  task automatic test_mixed_idle_with_drain();
    run_phase(100, 34, 34, 8'd4, 8'd2, 8'd9, 1'b1);
  endtask

  task automatic test_register_extremes();
    run_phase(40, 34, 34, 8'd255, 8'd255, 8'd255, 1'b0);
    run_phase(40, 0, 0, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = dpt_pkg::REG_PRESS;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_timer_loads();
    test_debounce_edges();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle_with_drain();
    test_register_extremes();

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("debounce_and_pulse_timers regression: pass");
    end else begin
      $display("debounce_and_pulse_timers regression: fail");
    end
    $finish;
  end

  // Watchdog. This limit lies far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("debounce_and_pulse_timers regression: fail");
    $finish;
  end

endmodule
